[sv/trp_pkg.sv]
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants for the tab record parser and its lookup table.
// ----------------------------------------------------------------------------
package trp_pkg;

  // Command codes carried in the input tuser field
  typedef enum logic [1:0] {
    CMD_FEED   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Blob byte codes
  localparam logic [7:0] NUL_BYTE  = 8'h00;
  localparam logic [7:0] TAB_BYTE  = 8'h09;
  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] NINE_CHAR = 8'h39;

  // Slot accumulator saturation value
  localparam int unsigned SLOT_W  = 9;
  localparam logic [SLOT_W-1:0] SLOT_SAT = 9'd256;

  // Output field widths
  localparam int unsigned NAME_W  = 10;
  localparam int unsigned OIDX_W  = 5;
  localparam int unsigned OCNT_W  = 6;

  // One stored table entry
  typedef struct packed {
    logic [7:0]        slot;
    logic [NAME_W-1:0] offset;
    logic [NAME_W-1:0] length;
  } entry_t;

  // Commit report from the parser
  typedef struct packed {
    logic   stored;
    entry_t entry;
  } commit_t;

  // Pending result fields before packing
  typedef struct packed {
    logic   entry_valid;
    logic   found;
    entry_t entry;
  } res_t;

endpackage

[sv/trp_table.sv]
// ----------------------------------------------------------------------------
// trp_table
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module trp_table
  import trp_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[sv/trp_parser.sv]
// ----------------------------------------------------------------------------
// trp_parser
// Line parser: takes one blob byte per step and reports completed entries.
// ----------------------------------------------------------------------------
module trp_parser
  import trp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned BLOB_BYTES  = 1024,
  parameter int unsigned IDX_W       = 5,
  parameter int unsigned CNT_W       = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             first_i,
  output commit_t          commit_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output logic [CNT_W-1:0] count_o,
  output logic             halted_o
);

  localparam int unsigned POS_W = $clog2(BLOB_BYTES + 1);

  typedef enum logic [2:0] {
    PH_DIGIT0 = 3'b001,
    PH_DIGITS = 3'b010,
    PH_NAME   = 3'b100
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              halted_q, halted_d;
  logic [SLOT_W-1:0] accum_q, accum_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  nstart_q, nstart_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              digit;
  logic [3:0]        dval;
  logic [12:0]       prod;
  logic [POS_W-1:0]  pos_cur;
  logic [POS_W-1:0]  pos_nxt;
  logic [POS_W-1:0]  name_len;
  commit_t           commit;
  logic [IDX_W-1:0]  wr_addr;

  assign digit   = (byte_i >= ZERO_CHAR) && (byte_i <= NINE_CHAR);
  assign dval    = 4'(byte_i - ZERO_CHAR);
  // Times ten by shift and add
  assign prod    = 13'({accum_q, 3'b000}) + 13'({accum_q, 1'b0}) + 13'(dval);

  // Next parse state for one byte
  always_comb begin
    phase_d  = phase_q;
    halted_d = halted_q;
    accum_d  = accum_q;
    pos_d    = pos_q;
    nstart_d = nstart_q;
    cnt_d    = cnt_q;
    pos_cur  = '0;
    pos_nxt  = '0;
    name_len = '0;
    commit   = '0;
    wr_addr  = '0;

    if (step_i) begin
      // Restart on a new blob
      if (first_i) begin
        phase_d  = PH_DIGIT0;
        halted_d = 1'b0;
        accum_d  = '0;
        pos_d    = '0;
        nstart_d = '0;
        cnt_d    = '0;
      end

      if (!halted_d && (pos_d >= POS_W'(BLOB_BYTES))) begin
        halted_d = 1'b1;
      end

      if (!halted_d) begin
        pos_cur = pos_d;
        pos_nxt = pos_d + POS_W'(1);
        pos_d   = pos_nxt;

        case (phase_d)
          PH_DIGIT0: begin
            if (digit) begin
              accum_d = SLOT_W'(dval);
              phase_d = PH_DIGITS;
            end else begin
              halted_d = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (digit) begin
              accum_d = (prod > 13'(SLOT_SAT)) ? SLOT_SAT : SLOT_W'(prod);
            end else if (byte_i == TAB_BYTE && accum_d != '0 && !accum_d[SLOT_W-1]) begin
              nstart_d = pos_nxt;
              phase_d  = PH_NAME;
            end else begin
              halted_d = 1'b1;
            end
          end
          PH_NAME: begin
            if (byte_i == LF_BYTE || byte_i == NUL_BYTE) begin
              name_len = pos_cur - nstart_d;
              if (name_len != '0) begin
                commit.stored       = 1'b1;
                commit.entry.slot   = accum_d[7:0];
                commit.entry.offset = NAME_W'(nstart_d);
                commit.entry.length = NAME_W'(name_len);
                wr_addr             = cnt_d[IDX_W-1:0];
                cnt_d               = cnt_d + CNT_W'(1);
                if (cnt_d >= CNT_W'(MAX_ENTRIES)) begin
                  halted_d = 1'b1;
                end
              end
              phase_d = PH_DIGIT0;
              if (byte_i == NUL_BYTE) begin
                halted_d = 1'b1;
              end
            end
          end
          default: begin
            halted_d = 1'b1;
          end
        endcase

        // End of blob: store a name in progress, then halt
        if (!halted_d && (pos_nxt >= POS_W'(BLOB_BYTES))) begin
          if (phase_d == PH_NAME && pos_nxt > nstart_d) begin
            name_len            = pos_nxt - nstart_d;
            commit.stored       = 1'b1;
            commit.entry.slot   = accum_d[7:0];
            commit.entry.offset = NAME_W'(nstart_d);
            commit.entry.length = NAME_W'(name_len);
            wr_addr             = cnt_d[IDX_W-1:0];
            cnt_d               = cnt_d + CNT_W'(1);
          end
          halted_d = 1'b1;
        end
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DIGIT0;
      halted_q <= 1'b0;
      accum_q  <= '0;
      pos_q    <= '0;
      nstart_q <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      halted_q <= halted_d;
      accum_q  <= accum_d;
      pos_q    <= pos_d;
      nstart_q <= nstart_d;
      cnt_q    <= cnt_d;
    end
  end

  assign commit_o  = commit;
  assign wr_addr_o = wr_addr;
  assign count_o   = cnt_q;
  assign halted_o  = halted_q;

  // Table never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  // A full table halts the parse
  a_full_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_W'(MAX_ENTRIES)) |-> halted_q)
    else $error("table full but parse running");

  // A new blob restarts the position
  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && first_i) |=> (pos_q <= POS_W'(1)))
    else $error("position not restarted on first byte");

endmodule

[sv/tab_record_parser_table.sv]
// ----------------------------------------------------------------------------
// tab_record_parser_table
// Parses tab separated slot/name records into a table and answers lookups.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-------------------------
//  s_axis    | in        | tvalid / tready          | tdata: byte, slot, index
//            |           |                          | tuser: cmd, first
//  m_axis    | out       | tvalid / tready          | tdata: entry and status
//            |           |                          | tuser: entry_valid, found
//  cfg       | in        | cfg_valid_i / cfg_ready_o| cfg_data_i: ask_enable
//
//  A feed or an in-range get-by-index transaction passes through PARSE or
//  READ, then RESP, before the next accept; a slot lookup scans the entries
//  in SCAN (at most the entry count), one table read and compare per cycle.
//  The input is not ready while a transaction is in work. A result waiting
//  in the output register does not block the next accept, only the next load.
//  Reset clears the parse state and the entry count; no table clearing pass.
// ----------------------------------------------------------------------------
module tab_record_parser_table
  import trp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned BLOB_BYTES  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte [7:0], slot_query [15:8], index_query [21:16], zero [23:22]
  input  logic [23:0] s_axis_tdata,
  // cmd [1:0], first [2]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot_out [7:0], name_offset [17:8], name_length [27:18],
  // entry_index [32:28], entry_count [38:33], should_ask [39],
  // parse_stopped [40], zero [47:41]
  output logic [47:0] m_axis_tdata,
  // entry_valid [0], found [1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PARSE = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic             ask_q;
  logic [7:0]       byte_q;
  logic             first_q;
  logic [7:0]       sq_q;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  res_t             res_q, res_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic             m_valid_q;
  logic [47:0]      m_data_q;
  logic [1:0]       m_user_q;

  logic             s_accept;
  logic             out_free;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W:0]   scan_nxt;
  cmd_e             in_cmd;
  logic [7:0]       in_sq;
  logic [5:0]       in_iq;

  commit_t          commit;
  logic [IDX_W-1:0] wr_addr;
  logic [CNT_W-1:0] count;
  logic             halted;
  entry_t           rd_data;

  assign in_cmd   = cmd_e'(s_axis_tuser[1:0]);
  assign in_sq    = s_axis_tdata[15:8];
  assign in_iq    = s_axis_tdata[21:16];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign scan_nxt = (CNT_W + 1)'(rd_idx_q) + (CNT_W + 1)'(1);

  // Parser
  trp_parser #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .BLOB_BYTES  (BLOB_BYTES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (state_q == ST_PARSE),
    .byte_i    (byte_q),
    .first_i   (first_q),
    .commit_o  (commit),
    .wr_addr_o (wr_addr),
    .count_o   (count),
    .halted_o  (halted)
  );

  // Entry store
  trp_table #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   ((state_q == ST_PARSE) && commit.stored),
    .wr_addr_i (wr_addr),
    .wr_data_i (commit.entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    res_d     = res_q;
    res_idx_d = res_idx_q;
    rd_en     = 1'b0;
    rd_addr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          res_d     = '0;
          res_idx_d = '0;
          case (in_cmd)
            CMD_FEED: begin
              state_d = ST_PARSE;
            end
            CMD_LOOKUP: begin
              if (in_sq != 8'd0 && count != '0) begin
                rd_en    = 1'b1;
                rd_addr  = '0;
                rd_idx_d = '0;
                state_d  = ST_SCAN;
              end else begin
                state_d = ST_RESP;
              end
            end
            CMD_GET: begin
              if (7'(in_iq) < 7'(count) && 7'(in_iq) < 7'(MAX_ENTRIES)) begin
                rd_en    = 1'b1;
                rd_addr  = in_iq[IDX_W-1:0];
                rd_idx_d = in_iq[IDX_W-1:0];
                state_d  = ST_READ;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_PARSE: begin
        res_d.entry_valid = commit.stored;
        res_d.entry       = commit.stored ? commit.entry : '0;
        res_idx_d         = commit.stored ? wr_addr : '0;
        state_d           = ST_RESP;
      end
      ST_READ: begin
        res_d.found = 1'b1;
        res_d.entry = rd_data;
        res_idx_d   = rd_idx_q;
        state_d     = ST_RESP;
      end
      ST_SCAN: begin
        // Compare one entry, then read the next or stop
        if (rd_data.slot == sq_q) begin
          res_d.found = 1'b1;
          res_d.entry = rd_data;
          res_idx_d   = rd_idx_q;
          state_d     = ST_RESP;
        end else if (scan_nxt < (CNT_W + 1)'(count)) begin
          rd_en    = 1'b1;
          rd_addr  = scan_nxt[IDX_W-1:0];
          rd_idx_d = scan_nxt[IDX_W-1:0];
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ask_q     <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        ask_q <= cfg_data_i;
      end
      if (state_q == ST_RESP && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Transaction payload and result registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      byte_q  <= s_axis_tdata[7:0];
      first_q <= s_axis_tuser[2];
      sq_q    <= in_sq;
    end
    rd_idx_q  <= rd_idx_d;
    res_q     <= res_d;
    res_idx_q <= res_idx_d;
    if (state_q == ST_RESP && out_free) begin
      m_user_q <= {res_q.found, res_q.entry_valid};
      m_data_q <= {7'd0,
                   halted,
                   ask_q && (count != '0),
                   OCNT_W'(count),
                   OIDX_W'(res_idx_q),
                   res_q.entry.length,
                   res_q.entry.offset,
                   res_q.entry.slot};
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // An accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q != ST_IDLE))
    else $error("accepted transaction left sequencer idle");

  // Leaving the response state always presents a result
  a_resp_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_free) |=> m_valid_q)
    else $error("response dropped");

  // A found entry lies below the entry count
  a_found_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && res_q.found) |-> (CNT_W'(res_idx_q) < count))
    else $error("found entry outside table");

  // Entry report and query report never coincide
  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |-> !(res_q.found && res_q.entry_valid))
    else $error("result both stored and found");

endmodule

[tb/tab_record_parser_table_tb.sv]
// ----------------------------------------------------------------------------
// tab_record_parser_table_tb
// Self-checking bench for the tab record parser and its lookup table. Blob
// bytes, slot lookups and index reads are streamed in with random bursts and
// gaps. The output side stalls on its own pattern. Each result is checked
// field by field against an in-bench model of the parse state and the table.
// ----------------------------------------------------------------------------
module tab_record_parser_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trp_pkg::*;

  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned BLOB_BYTES  = 1024;

  typedef enum logic [1:0] {
    PH_LINE_START,
    PH_SLOT_DIGITS,
    PH_NAME_BYTES
  } parse_phase_e;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_e;

  // One result transaction, unpacked
  typedef struct packed {
    logic       entry_valid;
    logic       found;
    logic [7:0] slot;
    logic [9:0] offset;
    logic [9:0] length;
    logic [4:0] idx;
    logic [5:0] count;
    logic       ask;
    logic       stopped;
  } record_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  // byte [7:0], slot_query [15:8], index_query [21:16], zero [23:22]
  logic [23:0] s_axis_tdata  = '0;
  // cmd [1:0], first [2]
  logic [2:0]  s_axis_tuser  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // slot_out [7:0], name_offset [17:8], name_length [27:18],
  // entry_index [32:28], entry_count [38:33], should_ask [39],
  // parse_stopped [40], zero [47:41]
  logic [47:0] m_axis_tdata;
  // entry_valid [0], found [1]
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;

  // Parser and table mirror
  logic         ask_en     = 1'b1;
  parse_phase_e phase_q    = PH_LINE_START;
  logic         halt_q     = 1'b0;
  logic [8:0]   slot_acc   = '0;
  int unsigned  byte_pos   = 0;
  int unsigned  name_begin = 0;
  int unsigned  entry_cnt  = 0;
  entry_t       tbl_mirror [MAX_ENTRIES];

  record_result_t pending_results [$];
  int unsigned    mismatch_count = 0;
  int unsigned    items_sent     = 0;

  // Sender pacing and blob control
  bit          idle_enable = 1'b0;
  bit          mix_queries = 1'b0;
  bit          blob_start  = 1'b0;
  int unsigned burst_left  = 0;

  // Receiver pattern
  rx_pattern_e rx_mode = RX_ALWAYS;
  int unsigned rx_tick = 0;

  tab_record_parser_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .BLOB_BYTES (BLOB_BYTES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Store a finished name in the mirror table; halt once the table is full
  function automatic int unsigned commit_entry(int unsigned len);
    int unsigned i;
    i = entry_cnt;
    tbl_mirror[i].slot   = slot_acc[7:0];
    tbl_mirror[i].offset = name_begin[9:0];
    tbl_mirror[i].length = len[9:0];
    entry_cnt++;
    if (entry_cnt >= MAX_ENTRIES) halt_q = 1'b1;
    return i;
  endfunction

  function automatic record_result_t with_entry(record_result_t r, int unsigned i);
    r.slot   = tbl_mirror[i].slot;
    r.offset = tbl_mirror[i].offset;
    r.length = tbl_mirror[i].length;
    r.idx    = i[4:0];
    return r;
  endfunction

  // Advance the mirror by one transaction and return the result it causes
  function automatic record_result_t compute_record_result(cmd_e cmd, logic [7:0] b,
                                                           logic first_flag,
                                                           logic [7:0] slot_q,
                                                           logic [5:0] idx_q);
    record_result_t r;
    int unsigned    pos;
    int unsigned    v;
    int unsigned    at;
    bit             digit;
    bit             stored;
    r      = '0;
    stored = 1'b0;
    at     = 0;
    case (cmd)
      CMD_FEED: begin
        if (first_flag) begin
          phase_q    = PH_LINE_START;
          halt_q     = 1'b0;
          slot_acc   = '0;
          byte_pos   = 0;
          name_begin = 0;
          entry_cnt  = 0;
        end
        if (!halt_q && byte_pos >= BLOB_BYTES) halt_q = 1'b1;
        if (!halt_q) begin
          pos      = byte_pos;
          digit    = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
          byte_pos = pos + 1;
          case (phase_q)
            PH_LINE_START: begin
              if (digit) begin
                slot_acc = 9'(b - ZERO_CHAR);
                phase_q  = PH_SLOT_DIGITS;
              end else begin
                halt_q = 1'b1;
              end
            end
            PH_SLOT_DIGITS: begin
              if (digit) begin
                v        = slot_acc * 10 + (b - ZERO_CHAR);
                slot_acc = (v > SLOT_SAT) ? SLOT_SAT : v[8:0];
              end else if (b == TAB_BYTE && slot_acc != 0 && slot_acc <= 255) begin
                name_begin = pos + 1;
                phase_q    = PH_NAME_BYTES;
              end else begin
                halt_q = 1'b1;
              end
            end
            default: begin
              if (b == LF_BYTE || b == NUL_BYTE) begin
                if (pos > name_begin) begin
                  at     = commit_entry(pos - name_begin);
                  stored = 1'b1;
                end
                phase_q = PH_LINE_START;
                if (b == NUL_BYTE) halt_q = 1'b1;
              end
            end
          endcase
          // Close the blob on its last byte, keeping a name in progress
          if (!halt_q && pos + 1 >= BLOB_BYTES) begin
            if (phase_q == PH_NAME_BYTES && pos + 1 > name_begin) begin
              at     = commit_entry(pos + 1 - name_begin);
              stored = 1'b1;
            end
            halt_q = 1'b1;
          end
          if (stored) begin
            r             = with_entry(r, at);
            r.entry_valid = 1'b1;
          end
        end
      end
      CMD_LOOKUP: begin
        if (slot_q != 0) begin
          for (int i = 0; i < entry_cnt; i++) begin
            if (!r.found && tbl_mirror[i].slot == slot_q) begin
              r       = with_entry(r, i);
              r.found = 1'b1;
            end
          end
        end
      end
      CMD_GET: begin
        if (idx_q < entry_cnt) begin
          r       = with_entry(r, idx_q);
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.count   = entry_cnt[5:0];
    r.ask     = ask_en && (entry_cnt > 0);
    r.stopped = halt_q;
    return r;
  endfunction

  function automatic void compare_field(string fname, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  function automatic logic [7:0] random_name_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == LF_BYTE || b == NUL_BYTE);
    return b;
  endfunction

  // Send one transaction in bursts with random gaps; valid stays high on return
  task automatic send_item(cmd_e cmd, logic [7:0] data_b, logic first_flag,
                           logic [7:0] slot_q, logic [5:0] idx_q);
    int unsigned gap;
    if (idle_enable && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tdata  <= {2'b00, idx_q, slot_q, data_b};
    s_axis_tuser  <= {first_flag, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(compute_record_result(cmd, data_b, first_flag, slot_q, idx_q));
    items_sent++;
  endtask

  task automatic send_random_query();
    int unsigned pick;
    logic [7:0]  slot_q;
    logic [5:0]  idx_q;
    pick   = $urandom_range(0, 9);
    slot_q = 8'($urandom_range(0, 255));
    idx_q  = 6'($urandom_range(0, 63));
    if (pick < 6) begin
      if (pick < 5 && entry_cnt > 0) slot_q = tbl_mirror[$urandom_range(0, entry_cnt - 1)].slot;
      send_item(CMD_LOOKUP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), slot_q,
                idx_q);
    end else if (pick < 9) begin
      if (pick < 8) idx_q = 6'($urandom_range(0, entry_cnt + 1));
      send_item(CMD_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), slot_q, idx_q);
    end else begin
      send_item(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), slot_q, idx_q);
    end
  endtask

  // Feed one blob byte; the first byte after begin of a blob carries the first flag
  task automatic feed_byte(logic [7:0] b);
    if (mix_queries && $urandom_range(0, 9) == 0) send_random_query();
    send_item(CMD_FEED, b, blob_start, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
    blob_start = 1'b0;
  endtask

  task automatic feed_text(string text);
    for (int i = 0; i < text.len(); i++) feed_byte(text[i]);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ask_enable(logic value);
    wait_for_results();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    ask_en = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Empty table queries, max slot, empty name, name closed by NUL, halted byte
  task automatic test_directed_records();
    send_item(CMD_NONE, 8'hFF, 1'b1, 8'hFF, 6'h3F);
    send_item(CMD_LOOKUP, 8'h00, 1'b0, 8'd5, 6'd0);
    send_item(CMD_GET, 8'h00, 1'b0, 8'd0, 6'd63);
    blob_start = 1'b1;
    feed_text("255\tZ\n3\t\n9\tab");
    feed_byte(NUL_BYTE);
    feed_byte("7");
    send_item(CMD_LOOKUP, 8'h00, 1'b0, 8'd255, 6'd0);
    send_item(CMD_LOOKUP, 8'h00, 1'b0, 8'd0, 6'd0);
    send_item(CMD_LOOKUP, 8'h00, 1'b0, 8'd9, 6'd0);
    send_item(CMD_GET, 8'h00, 1'b0, 8'd0, 6'd0);
    send_item(CMD_GET, 8'h00, 1'b0, 8'd0, 6'd1);
    send_item(CMD_GET, 8'h00, 1'b0, 8'd0, 6'd2);
    send_item(CMD_GET, 8'h00, 1'b0, 8'd0, 6'd63);
  endtask

  // Slot above range, saturation, slot zero, missing digit, missing tab and leading zeros
  task automatic test_malformed_lines();
    blob_start = 1'b1;
    feed_text("256\tA");
    blob_start = 1'b1;
    feed_text("99999\t");
    blob_start = 1'b1;
    feed_text("0\t");
    blob_start = 1'b1;
    feed_text("x");
    blob_start = 1'b1;
    feed_text("5x");
    blob_start = 1'b1;
    feed_text("00012\tn\n\t");
    send_item(CMD_LOOKUP, 8'h00, 1'b0, 8'd12, 6'd0);
    blob_start = 1'b1;
    feed_byte(NUL_BYTE);
  endtask

  // Overfill the table with repeated slots, then read it all back
  task automatic test_table_full();
    int unsigned slot_v;
    idle_enable = 1'b1;
    blob_start  = 1'b1;
    for (int i = 0; i < 34; i++) begin
      slot_v = (i < 20) ? i + 1 : (i % 7) + 1;
      feed_text($sformatf("%0d\t", slot_v));
      repeat ($urandom_range(1, 3)) feed_byte(random_name_byte());
      feed_byte(LF_BYTE);
    end
    for (int s = 0; s <= 21; s++)
      send_item(CMD_LOOKUP, 8'($urandom_range(0, 255)), 1'b0, 8'(s),
                6'($urandom_range(0, 63)));
    send_item(CMD_LOOKUP, 8'h00, 1'b0, 8'd255, 6'd0);
    for (int i = 0; i <= 33; i++)
      send_item(CMD_GET, 8'($urandom_range(0, 255)), 1'b1, 8'($urandom_range(0, 255)),
                6'(i));
    send_item(CMD_GET, 8'h00, 1'b0, 8'd0, 6'd63);
  endtask

  // Long names until the blob size is used up
  task automatic test_blob_end();
    int unsigned name_len;
    mix_queries = 1'b1;
    blob_start  = 1'b1;
    while (!halt_q || blob_start) begin
      feed_text($sformatf("%0d\t", $urandom_range(1, 255)));
      name_len = $urandom_range(100, 300);
      for (int n = 0; n < name_len && !halt_q; n++) feed_byte(random_name_byte());
      if (!halt_q) feed_byte(LF_BYTE);
    end
    feed_byte("1");
    feed_byte(TAB_BYTE);
    mix_queries = 1'b0;
    for (int i = 0; i < 8; i++)
      send_item(CMD_GET, 8'h00, 1'b0, 8'd0, 6'(i));
    repeat (4) send_random_query();
  endtask

  // One random line: mostly well formed, sometimes malformed
  task automatic emit_random_line();
    int unsigned kind;
    int unsigned slot_v;
    int unsigned name_len;
    logic [7:0]  b;
    kind = $urandom_range(0, 15);
    case (kind)
      0: feed_byte(8'($urandom_range(0, 255)));
      1: feed_text($urandom_range(0, 1) ? "0\t" : "00\t");
      2: begin
        feed_text($sformatf("%0d", $urandom_range(256, 99999)));
        feed_byte(TAB_BYTE);
      end
      3: begin
        feed_text($sformatf("%0d", $urandom_range(1, 255)));
        do b = 8'($urandom_range(0, 255));
        while ((b >= ZERO_CHAR && b <= NINE_CHAR) || b == TAB_BYTE);
        feed_byte(b);
      end
      default: begin
        slot_v = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 255);
        if ($urandom_range(0, 7) == 0) feed_byte(ZERO_CHAR);
        feed_text($sformatf("%0d", slot_v));
        feed_byte(TAB_BYTE);
        name_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
        repeat (name_len) feed_byte(random_name_byte());
        feed_byte(($urandom_range(0, 19) == 0) ? NUL_BYTE : LF_BYTE);
      end
    endcase
  endtask

  task automatic run_random_blob();
    int unsigned lines;
    lines       = ($urandom_range(0, 7) == 0) ? 36 : $urandom_range(1, 10);
    mix_queries = 1'b1;
    blob_start  = 1'b1;
    for (int l = 0; l < lines; l++) begin
      emit_random_line();
      if (halt_q) break;
    end
    if (halt_q) repeat ($urandom_range(0, 2)) feed_byte(8'($urandom_range(0, 255)));
    else if ($urandom_range(0, 2) == 0) feed_byte(NUL_BYTE);
    mix_queries = 1'b0;
    repeat ($urandom_range(1, 4)) send_random_query();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    bit          cfg_switched;
    start        = items_sent;
    cfg_switched = 1'b0;
    while (items_sent - start < 200) begin
      // Hold off in mid run until the output drains, then flip the setting
      if (!cfg_switched && items_sent - start >= 100) begin
        write_ask_enable(1'b0);
        cfg_switched = 1'b1;
      end
      idle_enable = ($urandom_range(0, 3) != 0);
      run_random_blob();
    end
  endtask

  // Stall the output side on a pattern picked at random from a set of four
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 80 == 0) rx_mode <= rx_pattern_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
      default:   m_axis_tready <= (rx_tick % 10) >= 6;
    endcase
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin : check_results
    record_result_t exp_r;
    record_result_t act_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_r = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[7:0], m_axis_tdata[17:8],
               m_axis_tdata[27:18], m_axis_tdata[32:28], m_axis_tdata[38:33],
               m_axis_tdata[39], m_axis_tdata[40]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tuser=%h tdata=%h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("entry_valid", exp_r.entry_valid, act_r.entry_valid);
        compare_field("found", exp_r.found, act_r.found);
        compare_field("slot_out", exp_r.slot, act_r.slot);
        compare_field("name_offset", exp_r.offset, act_r.offset);
        compare_field("name_length", exp_r.length, act_r.length);
        compare_field("entry_index", exp_r.idx, act_r.idx);
        compare_field("entry_count", exp_r.count, act_r.count);
        compare_field("should_ask", exp_r.ask, act_r.ask);
        compare_field("parse_stopped", exp_r.stopped, act_r.stopped);
      end
    end
  end

  // Main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed_records();
    write_ask_enable(1'b0);
    test_malformed_lines();
    write_ask_enable(1'b1);
    test_table_full();
    write_ask_enable(1'b0);
    test_blob_end();
    write_ask_enable(1'b1);
    test_random_traffic();
    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
